>>> hw/rtl/matrix_chain_min_cost_core_defines.svh
// Assertion macros shared by the matrix chain cost RTL.
`ifndef MATRIX_CHAIN_MIN_COST_CORE_DEFINES_SVH
`define MATRIX_CHAIN_MIN_COST_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mcmc_pkg.sv
// Types and constants of the matrix chain minimum cost block.
package mcmc_pkg;

    localparam int DIM_FIELD_W = 16;
    localparam int COST_W      = 64;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 2'd2;

    typedef struct packed {
        logic [DIM_FIELD_W-1:0] dimension;
        logic                   last_dimension;
    } chain_in_t;

    typedef struct packed {
        logic [COST_W-1:0]   min_cost;
        logic [STATUS_W-1:0] status;
    } chain_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_SETUP_C,
        ST_LOOP,
        ST_DRAIN
    } chain_state_t;

endpackage

>>> hw/rtl/matrix_chain_min_cost_core.sv
// Matrix chain minimum cost core: dimension loader, interval DP sequencer and cost memory.
//
// The block collects the dimension list d[0..n] of a chain of n matrices, one
// dimension per item, and the item marked last starts the interval dynamic
// program; it then returns one item holding the least number of scalar
// multiplications and a status (ok, saturated at all ones, or bad count when
// the list has fewer than two or more than MAX_MATRICES+1 dimensions). Items
// without the last mark are stored one after another and give no result. A
// list that is rejected, or that holds a single matrix, answers in the cycle
// after its last item is taken. Otherwise each interval is worked in turn:
// the states ST_SETUP_A to ST_SETUP_C fetch its end dimensions and form their
// product, one split point is issued per cycle because the cost memory reads
// both sub-interval costs through its two read ports at once, and the
// four-stage multiply, add and compare pipeline drains before the interval's
// cost is written back. Draining before each write-back is also the
// interlock: no interval reads an entry still in flight. Neither memory needs
// a clearing pass; the diagonal costs are zero by construction. The block
// accepts no new item while a list is being worked on, and holds a last item
// back until an earlier result has been taken.

`include "matrix_chain_min_cost_core_defines.svh"

module matrix_chain_min_cost_core #(
    parameter int MAX_MATRICES = 32,
    parameter int DIM_BITS     = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  mcmc_pkg::chain_in_t  src_item,
    output logic                res_valid,
    input  logic                res_stall,
    output mcmc_pkg::chain_out_t res_item
);

    import mcmc_pkg::*;

    // Store and counter geometry.
    localparam int STORE_DEPTH    = MAX_MATRICES + 1;
    localparam int COUNT_OVERFLOW = MAX_MATRICES + 2;
    localparam int COST_DEPTH     = MAX_MATRICES * MAX_MATRICES;
    localparam int IDX_W  = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
    localparam int DA_W   = $clog2(STORE_DEPTH);
    localparam int CA_W   = (COST_DEPTH > 1) ? $clog2(COST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(COUNT_OVERFLOW + 1);
    // Arithmetic widths: one dimension, a product of two, a product of three.
    localparam int DB  = DIM_BITS;
    localparam int PW2 = 2 * DIM_BITS;
    localparam int PW3 = 3 * DIM_BITS;

    // Saturating 64-bit add.
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

    // Memories.
    logic [DB-1:0]     dim_mem  [STORE_DEPTH];
    logic [COST_W-1:0] cost_mem [COST_DEPTH];

    logic [DB-1:0]     dim_rd_reg;
    logic [COST_W-1:0] ca_rd_reg;
    logic [COST_W-1:0] cb_rd_reg;

    logic              dim_we;
    logic [DA_W-1:0]   dim_waddr;
    logic [DA_W-1:0]   dim_raddr;
    logic [DB-1:0]     dim_wdata;
    logic              cost_we;
    logic [CA_W-1:0]   cost_waddr;
    logic [CA_W-1:0]   cost_raddr_a;
    logic [CA_W-1:0]   cost_raddr_b;

    // Control state.
    chain_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  nm1_reg, nm1_next;
    logic [IDX_W-1:0]  i0_reg, i0_next;
    logic [IDX_W-1:0]  j0_reg, j0_next;
    logic [IDX_W-1:0]  k0_reg, k0_next;
    logic              res_valid_reg, res_valid_next;

    // Payload state.
    logic [DB-1:0]     di_reg, di_next;
    logic [PW2-1:0]    a_reg, a_next;
    logic [COST_W-1:0] best_reg, best_next;
    chain_out_t        res_reg, res_next;

    // Split pipeline.
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              za1_reg, zb1_reg;
    logic [PW2-1:0]    pl_reg, ph_reg;
    logic [COST_W-1:0] sum2_reg, sum3_reg, cand_reg;
    logic [PW3-1:0]    prod_reg;

    logic              src_acc;
    logic              issue;
    logic              pipe_empty;
    logic [CNT_W-1:0]  cnt_plus;
    logic [DB-1:0]     dim_in;

    assign dim_in     = DB'(src_item.dimension);
    assign issue      = (state_reg == ST_LOOP);
    assign pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign src_stall  = (state_reg != ST_IDLE) || (src_item.last_dimension && res_valid_reg);
    assign src_acc    = src_valid && !src_stall;
    assign cnt_plus   = (cnt_reg < CNT_W'(COUNT_OVERFLOW)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    // The sub-interval costs of split k: cost[i][k] and cost[k+1][j].
    assign cost_raddr_a = CA_W'(i0_reg) * CA_W'(MAX_MATRICES) + CA_W'(k0_reg);
    assign cost_raddr_b = (CA_W'(k0_reg) + CA_W'(1)) * CA_W'(MAX_MATRICES) + CA_W'(j0_reg);
    assign cost_waddr   = CA_W'(i0_reg) * CA_W'(MAX_MATRICES) + CA_W'(j0_reg);
    assign dim_waddr    = cnt_reg[DA_W-1:0];
    assign dim_wdata    = dim_in;

    always_ff @(posedge clk)
    begin
        if (dim_we)
        begin
            dim_mem[dim_waddr] <= dim_wdata;
        end
        dim_rd_reg <= dim_mem[dim_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[cost_waddr] <= best_reg;
        end
        ca_rd_reg <= cost_mem[cost_raddr_a];
        cb_rd_reg <= cost_mem[cost_raddr_b];
    end

    // Sequencer: loads dimensions, walks intervals by length, issues splits.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        nm1_next       = nm1_reg;
        i0_next        = i0_reg;
        j0_next        = j0_reg;
        k0_next        = k0_reg;
        di_next        = di_reg;
        a_next         = a_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        dim_we         = 1'b0;
        dim_raddr      = DA_W'(k0_reg) + DA_W'(1);
        cost_we        = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        // Keep the running minimum of the candidate costs.
        if (v4_reg && (cand_reg < best_reg))
        begin
            best_next = cand_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (src_acc)
                begin
                    dim_we = (cnt_reg < CNT_W'(STORE_DEPTH));
                    if (src_item.last_dimension)
                    begin
                        cnt_next = '0;
                        if ((cnt_plus < CNT_W'(2)) || (cnt_plus > CNT_W'(STORE_DEPTH)))
                        begin
                            res_next.min_cost = '0;
                            res_next.status   = STATUS_BAD_COUNT;
                            res_valid_next    = 1'b1;
                        end
                        else if (cnt_plus == CNT_W'(2))
                        begin
                            // A single matrix needs no multiplication.
                            res_next.min_cost = '0;
                            res_next.status   = STATUS_OK;
                            res_valid_next    = 1'b1;
                        end
                        else
                        begin
                            nm1_next   = IDX_W'(cnt_plus - CNT_W'(2));
                            i0_next    = '0;
                            j0_next    = IDX_W'(1);
                            state_next = ST_SETUP_A;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_plus;
                    end
                end
            end
            ST_SETUP_A:
            begin
                dim_raddr  = DA_W'(i0_reg);
                best_next  = {COST_W{1'b1}};
                k0_next    = i0_reg;
                state_next = ST_SETUP_B;
            end
            ST_SETUP_B:
            begin
                dim_raddr  = DA_W'(j0_reg) + DA_W'(1);
                di_next    = dim_rd_reg;
                state_next = ST_SETUP_C;
            end
            ST_SETUP_C:
            begin
                a_next     = PW2'(di_reg) * PW2'(dim_rd_reg);
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (k0_reg == j0_reg - IDX_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k0_next = k0_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    cost_we = 1'b1;
                    if ((i0_reg == '0) && (j0_reg == nm1_reg))
                    begin
                        // The whole chain is done.
                        res_next.min_cost = best_reg;
                        res_next.status   = (best_reg == {COST_W{1'b1}}) ?
                                            STATUS_SATURATED : STATUS_OK;
                        res_valid_next    = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else if (j0_reg == nm1_reg)
                    begin
                        // Move on to the first interval one longer.
                        i0_next    = '0;
                        j0_next    = j0_reg - i0_reg + IDX_W'(1);
                        state_next = ST_SETUP_A;
                    end
                    else
                    begin
                        i0_next    = i0_reg + IDX_W'(1);
                        j0_next    = j0_reg + IDX_W'(1);
                        state_next = ST_SETUP_A;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            nm1_reg       <= '0;
            i0_reg        <= '0;
            j0_reg        <= '0;
            k0_reg        <= '0;
            res_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            nm1_reg       <= nm1_next;
            i0_reg        <= i0_next;
            j0_reg        <= j0_next;
            k0_reg        <= k0_next;
            res_valid_reg <= res_valid_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
        end
    end

    // Payload registers and the split pipeline datapath.
    always_ff @(posedge clk)
    begin
        di_reg   <= di_next;
        a_reg    <= a_next;
        best_reg <= best_next;
        res_reg  <= res_next;
        // Diagonal entries are zero cost and are never read from memory.
        za1_reg  <= (k0_reg == i0_reg);
        zb1_reg  <= (k0_reg == j0_reg - IDX_W'(1));
        // The 2DB x DB product is split in two DB x DB halves.
        pl_reg   <= PW2'(a_reg[DB-1:0]) * PW2'(dim_rd_reg);
        ph_reg   <= PW2'(a_reg[PW2-1:DB]) * PW2'(dim_rd_reg);
        sum2_reg <= sat_add(za1_reg ? '0 : ca_rd_reg, zb1_reg ? '0 : cb_rd_reg);
        prod_reg <= PW3'(pl_reg) + (PW3'(ph_reg) << DB);
        sum3_reg <= sum2_reg;
        cand_reg <= sat_add(sum3_reg, COST_W'(prod_reg));
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    `MCMC_ASSERT_NOW(a_accept_only_idle, clk, rst_n, !src_stall, state_reg == ST_IDLE, "input taken while busy")
    `MCMC_ASSERT_NOW(a_write_after_drain, clk, rst_n, cost_we, pipe_empty, "cost written with splits in flight")
    `MCMC_ASSERT_NOW(a_bad_count_zero, clk, rst_n, res_valid_reg && (res_reg.status == STATUS_BAD_COUNT), res_reg.min_cost == '0, "bad count with nonzero cost")
    `MCMC_ASSERT_NOW(a_ok_not_saturated, clk, rst_n, res_valid_reg && (res_reg.status == STATUS_OK), res_reg.min_cost != {COST_W{1'b1}}, "saturated cost reported as ok")
    `MCMC_ASSERT_NEXT(a_loop_to_drain, clk, rst_n, issue && (k0_reg == j0_reg - IDX_W'(1)), state_reg == ST_DRAIN && v1_reg, "last split not followed by drain")

endmodule
